>>> hw/rtl/u8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
package u8d_pkg;

    localparam int          CP_W         = 21;
    localparam int          COUNT_W      = 3;
    localparam int          LEN_W        = 3;
    localparam int          HELD_W       = 2;
    localparam int          REPL_W       = 2;
    localparam int          FIFO_DEPTH   = 4;

    localparam logic [CP_W-1:0]    REPL_CP      = 21'h00FFFD;
    localparam logic [CP_W-1:0]    MIN_CP_2     = 21'h000080;
    localparam logic [CP_W-1:0]    MIN_CP_3     = 21'h000800;
    localparam logic [CP_W-1:0]    SURR_LO      = 21'h00D800;
    localparam logic [CP_W-1:0]    SURR_HI      = 21'h00DFFF;
    localparam logic [CP_W-1:0]    MIN_CP_4     = 21'h010000;
    localparam logic [CP_W-1:0]    MAX_CP       = 21'h10FFFF;

    localparam logic [LEN_W-1:0]   SEQ_NONE     = 3'd0;
    localparam logic [LEN_W-1:0]   SEQ_LEN_2    = 3'd2;
    localparam logic [LEN_W-1:0]   SEQ_LEN_3    = 3'd3;
    localparam logic [LEN_W-1:0]   SEQ_LEN_4    = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_ONE    = 3'd1;

    // one input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_t;

    // one result beat
    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [COUNT_W-1:0] byte_count;
        logic               is_valid;
        logic               last_of_run;
        logic               text_end;
    } out_t;

    // work for the back end: n_repl replacements, then an optional tail result
    typedef struct packed {
        logic [REPL_W-1:0]  n_repl;
        logic               has_tail;
        logic [REPL_W-1:0]  last_idx;
        logic [CP_W-1:0]    tail_cp;
        logic [COUNT_W-1:0] tail_count;
        logic               tail_valid;
        logic               fin;
    } job_t;

endpackage

>>> hw/rtl/utf8_stream_decoder.sv
// top level of the streaming utf-8 decoder with validation
//
//  channel  | direction | handshake            | beat
//  ---------+-----------+----------------------+---------------------------------
//  item     | in        | push / full          | data_byte, final_byte
//  result   | out       | empty / pop          | code_point, byte_count, is_valid,
//           |           |                      | last_of_run, text_end
//
// one byte is taken every cycle while the job queue has room
// a result reaches the ports after its job is registered in the queue, then loaded into the head once the head is free
// a byte that yields k results (k up to 4) keeps the back end busy until all k are popped
// the job queue (FIFO_DEPTH jobs) absorbs replacement bursts before full rises
// a result beat waits on the ports until popped; bytes keep coming meanwhile
// reset clears the open sequence, the queue and the result head at once
module utf8_stream_decoder #(
    parameter int FIFO_DEPTH = u8d_pkg::FIFO_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  u8d_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output u8d_pkg::out_t result
);
    import u8d_pkg::*;

    logic accept;
    logic job_push;
    job_t front_job;
    job_t fifo_job;
    logic fifo_full;
    logic fifo_empty;
    logic fifo_pop;

    // a byte is taken whenever the queue can hold the job it may make
    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    // classify each byte against the open sequence
    u8d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .job_push (job_push),
        .job      (front_job)
    );

    // decouples byte intake from result playout
    u8d_job_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (front_job),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .pop_job  (fifo_job),
        .empty    (fifo_empty)
    );

    // one result beat per cycle out of the head job while pop is high and a job is waiting
    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_job   (fifo_job),
        .fifo_empty (fifo_empty),
        .fifo_pop   (fifo_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

`ifndef SYNTHESIS
    // end of text always produces at least one result
    a_fin_makes_job: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.final_byte) |-> job_push)
        else $error("final byte produced no job");

    // a queued job never carries zero results
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (front_job.has_tail || (front_job.n_repl != '0)))
        else $error("empty job pushed");

    // text end is only flagged on the last beat of a run
    a_text_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.text_end) |-> result.last_of_run)
        else $error("text_end without last_of_run");

    // the back end only reloads when its head is free or finishing
    a_reload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_pop && !empty) |-> (pop && result.last_of_run))
        else $error("head job overwritten before it finished");
`endif

endmodule

>>> hw/rtl/u8d_front.sv
// front end: classifies each byte against the open sequence and builds at most one job for it
module u8d_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  u8d_pkg::in_t  item,
    output logic          job_push,
    output u8d_pkg::job_t job
);
    import u8d_pkg::*;

    logic [LEN_W-1:0]  seq_len_reg, seq_len_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [CP_W-1:0]   partial_reg, partial_next;

    logic [7:0]        b;
    logic              cont;
    logic [LEN_W-1:0]  held_plus;
    logic [CP_W-1:0]   cont_value;
    logic [LEN_W-1:0]  lead_len;
    logic [CP_W-1:0]   lead_bits;

    function automatic logic well_formed(input logic [CP_W-1:0] cp,
                                         input logic [LEN_W-1:0] len);
        logic ok;
        unique case (len)
            SEQ_LEN_2: ok = (cp >= MIN_CP_2);
            SEQ_LEN_3: ok = !((cp < MIN_CP_3) || ((cp >= SURR_LO) && (cp <= SURR_HI)));
            default:   ok = !((cp < MIN_CP_4) || (cp > MAX_CP));
        endcase
        return ok;
    endfunction

    assign b          = item.data_byte;
    assign cont       = (b[7:6] == 2'b10);
    assign held_plus  = {1'b0, held_reg} + 3'd1;
    assign cont_value = {partial_reg[CP_W-7:0], b[5:0]};

    // lead byte decode
    always_comb
    begin
        lead_len  = SEQ_NONE;
        lead_bits = '0;
        if (b[7:5] == 3'b110)
        begin
            lead_len  = SEQ_LEN_2;
            lead_bits = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            lead_len  = SEQ_LEN_3;
            lead_bits = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            lead_len  = SEQ_LEN_4;
            lead_bits = {18'd0, b[2:0]};
        end
    end

    always_comb
    begin
        seq_len_next    = seq_len_reg;
        held_next       = held_reg;
        partial_next    = partial_reg;
        job.n_repl      = '0;
        job.has_tail    = 1'b1;
        job.tail_cp     = REPL_CP;
        job.tail_count  = COUNT_ONE;
        job.tail_valid  = 1'b0;
        job.fin         = item.final_byte;

        if ((seq_len_reg != SEQ_NONE) && cont)
        begin
            if (held_plus >= seq_len_reg)
            begin
                // sequence complete
                job.tail_cp    = cont_value;
                job.tail_count = seq_len_reg;
                job.tail_valid = well_formed(cont_value, seq_len_reg);
                seq_len_next   = SEQ_NONE;
                held_next      = '0;
                partial_next   = '0;
            end
            else if (item.final_byte)
            begin
                // cut short by end of text
                job.n_repl   = held_reg;
                seq_len_next = SEQ_NONE;
                held_next    = '0;
                partial_next = '0;
            end
            else
            begin
                job.has_tail = 1'b0;
                partial_next = cont_value;
                held_next    = held_plus[HELD_W-1:0];
            end
        end
        else
        begin
            // held bytes (none when closed) are flushed, then the byte is taken as ascii, a lead or a replacement
            job.n_repl   = held_reg;
            seq_len_next = SEQ_NONE;
            held_next    = '0;
            partial_next = '0;
            if (!b[7])
            begin
                job.tail_cp    = {13'd0, b};
                job.tail_valid = 1'b1;
            end
            else if ((lead_len != SEQ_NONE) && !item.final_byte)
            begin
                job.has_tail = 1'b0;
                seq_len_next = lead_len;
                held_next    = 2'd1;
                partial_next = lead_bits;
            end
        end

        job.last_idx = job.has_tail ? job.n_repl : job.n_repl - 2'd1;
        job_push     = accept && (job.has_tail || (job.n_repl != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= SEQ_NONE;
            held_reg    <= '0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            seq_len_reg <= seq_len_next;
            held_reg    <= held_next;
            partial_reg <= partial_next;
        end
    end

endmodule

>>> hw/rtl/u8d_job_fifo.sv
// small register queue of jobs between front and back end
module u8d_job_fifo #(
    parameter int DEPTH = u8d_pkg::FIFO_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  u8d_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output u8d_pkg::job_t pop_job,
    output logic          empty
);
    import u8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hw/rtl/u8d_back.sv
// back end: plays out one job as a run of result beats
module u8d_back (
    input  logic          clk,
    input  logic          rst_n,
    input  u8d_pkg::job_t fifo_job,
    input  logic          fifo_empty,
    output logic          fifo_pop,
    input  logic          pop,
    output logic          empty,
    output u8d_pkg::out_t result
);
    import u8d_pkg::*;

    job_t              head_reg, head_next;
    logic              head_valid_reg, head_valid_next;
    logic [REPL_W-1:0] idx_reg, idx_next;
    logic              advance, at_last, is_repl;

    assign empty    = !head_valid_reg;
    assign advance  = head_valid_reg && pop;
    assign at_last  = (idx_reg == head_reg.last_idx);
    assign is_repl  = (idx_reg < head_reg.n_repl);
    assign fifo_pop = (!head_valid_reg || (advance && at_last)) && !fifo_empty;

    always_comb
    begin
        result.code_point  = is_repl ? REPL_CP : head_reg.tail_cp;
        result.byte_count  = is_repl ? COUNT_ONE : head_reg.tail_count;
        result.is_valid    = !is_repl && head_reg.tail_valid;
        result.last_of_run = at_last;
        result.text_end    = at_last && head_reg.fin;
    end

    always_comb
    begin
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        idx_next        = idx_reg;
        if (fifo_pop)
        begin
            head_next       = fifo_job;
            head_valid_next = 1'b1;
            idx_next        = '0;
        end
        else if (advance && at_last)
        begin
            head_valid_next = 1'b0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

endmodule
